### rtl/efla_pkg.sv
// Shared types and constants for the explicit free list allocator.
// Holds the sequencer state type, status codes and the memory request struct.
// No dependencies.
package efla_pkg;

    // Default sizes.
    localparam int HEAP_BYTES_DEF  = 65536;
    localparam int CHUNK_BYTES_DEF = 2048;

    // Smallest block: header, two links and footer.
    localparam logic [31:0] MIN_BLOCK = 32'd24;

    // Result status codes.
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_IGNORED = 2'd1;
    localparam logic [1:0] ST_NOMEM   = 2'd2;

    // Tag values written at reset.
    localparam logic [31:0] TAG_PROLOGUE = 32'd9;
    localparam logic [31:0] TAG_EPILOGUE = 32'd1;

    // Operation codes.
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // Sequencer states.
    typedef enum logic [5:0] {
        S_INIT, S_IDLE, S_A0, S_F0, S_F1, S_F2,
        S_G0, S_G1, S_G2, S_G3,
        S_M0, S_M1, S_M2, S_M3, S_M4, S_M5, S_M6,
        S_MPUSH, S_MREM2, S_MW0, S_MW1, S_MRET,
        S_R0, S_R1, S_R2, S_R3,
        S_P0, S_P1, S_P2,
        S_C0, S_C1, S_C2, S_C3, S_C4, S_C5, S_C6, S_C7, S_CFIN,
        S_FR0, S_FR1, S_FR2, S_FRFIN,
        S_DONE
    } state_t;

    // One word access request to the heap memory.
    typedef struct packed {
        logic [31:0] rd_addr;
        logic        wr_en;
        logic [31:0] wr_addr;
        logic [31:0] wr_data;
    } mem_req_t;

endpackage

### rtl/efla_mem.sv
// Heap word memory with one write and one registered read port.
// Depends on efla_pkg for the request struct.
// Accesses beyond the heap capacity read as zero and drop their writes.
module efla_mem
    import efla_pkg::*;
#(
    parameter int HEAP_BYTES = HEAP_BYTES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  mem_req_t    req,
    output logic [31:0] rdata
);

    localparam int CAP   = (HEAP_BYTES < 65536) ? HEAP_BYTES : 65536;
    localparam int WORDS = CAP / 4;
    localparam int IW    = $clog2(WORDS);
    localparam logic [31:0] CAP_W = 32'(CAP);

    logic [31:0] mem [WORDS];
    logic [31:0] q_reg;
    logic        inr_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (req.wr_en && (req.wr_addr < CAP_W))
        begin
            mem[req.wr_addr[IW+1:2]] <= req.wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        q_reg <= mem[req.rd_addr[IW+1:2]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inr_reg <= 1'b0;
        end
        else
        begin
            inr_reg <= (req.rd_addr < CAP_W);
        end
    end

    assign rdata = inr_reg ? q_reg : 32'd0;

endmodule

### rtl/efla_ctrl.sv
// Sequencer for the allocator: heap setup, first-fit walk, growth,
// coalescing and free list maintenance, one memory word per cycle.
// Depends on efla_pkg for states, codes and the memory request struct.
module efla_ctrl
    import efla_pkg::*;
#(
    parameter int HEAP_BYTES  = HEAP_BYTES_DEF,
    parameter int CHUNK_BYTES = CHUNK_BYTES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        op,
    input  logic [19:0] request_bytes,
    input  logic [15:0] block_address,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] payload_address,
    output logic [1:0]  status,
    output mem_req_t    mem_req,
    input  logic [31:0] rdata
);

    localparam int CAP   = (HEAP_BYTES < 65536) ? HEAP_BYTES : 65536;
    localparam int LIMIT = CAP / 24 + 1;
    localparam int SW    = $clog2(LIMIT + 1);
    localparam logic [31:0] CAP_W   = 32'(CAP);
    localparam logic [31:0] CHUNK_W = 32'(CHUNK_BYTES);
    localparam logic [SW-1:0] LIMIT_W = SW'(LIMIT);

    state_t state_reg, state_next;
    state_t link_ret_reg, link_ret_next;
    state_t merge_ret_reg, merge_ret_next;

    logic [2:0]  cnt_reg, cnt_next;
    logic [31:0] bp_reg, bp_next;
    logic [31:0] p_reg, p_next;
    logic [31:0] n_reg, n_next;
    logic [31:0] size_reg, size_next;
    logic [31:0] psz_reg, psz_next;
    logic [31:0] nsz_reg, nsz_next;
    logic [31:0] asize_reg, asize_next;
    logic [31:0] total_reg, total_next;
    logic [31:0] gbytes_reg, gbytes_next;
    logic [31:0] lr_reg, lr_next;
    logic [31:0] lp_reg, lp_next;
    logic [31:0] before_reg, before_next;
    logic [31:0] after_reg, after_next;
    logic [15:0] head_reg, head_next;
    logic [16:0] brk_reg, brk_next;
    logic [SW-1:0] steps_reg, steps_next;
    logic        pa_reg, pa_next;
    logic        na_reg, na_next;
    logic        used_reg, used_next;
    logic [19:0] req_reg, req_next;
    logic [15:0] res_pay_reg, res_pay_next;
    logic [1:0]  res_st_reg, res_st_next;
    logic        ovalid_reg, ovalid_next;
    logic [15:0] opay_reg, opay_next;
    logic [1:0]  ost_reg, ost_next;

    logic [31:0] d_sz;
    logic [31:0] brk_w;
    logic        accept;
    logic        out_free;
    logic        grow_fail;
    logic [20:0] req_round;

    function automatic logic inr(input logic [31:0] a);
        return a < CAP_W;
    endfunction

    // Shared decode of the word just read and of the pending request.
    assign d_sz      = {rdata[31:3], 3'b000};
    assign brk_w     = {15'd0, brk_reg};
    assign accept    = in_valid && in_ready;
    assign out_free  = !ovalid_reg || out_ready;
    assign grow_fail = (brk_w > CAP_W) || (size_reg > (CAP_W - brk_w));
    assign req_round = ({1'b0, req_reg} + 21'd15) & ~21'd7;

    assign in_ready        = (state_reg == S_IDLE);
    assign out_valid       = ovalid_reg;
    assign payload_address = opay_reg;
    assign status          = ost_reg;

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            link_ret_reg  <= S_IDLE;
            merge_ret_reg <= S_IDLE;
            cnt_reg       <= 3'd0;
            head_reg      <= 16'd0;
            brk_reg       <= 17'd24;
            ovalid_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            link_ret_reg  <= link_ret_next;
            merge_ret_reg <= merge_ret_next;
            cnt_reg       <= cnt_next;
            head_reg      <= head_next;
            brk_reg       <= brk_next;
            ovalid_reg    <= ovalid_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        bp_reg      <= bp_next;
        p_reg       <= p_next;
        n_reg       <= n_next;
        size_reg    <= size_next;
        psz_reg     <= psz_next;
        nsz_reg     <= nsz_next;
        asize_reg   <= asize_next;
        total_reg   <= total_next;
        gbytes_reg  <= gbytes_next;
        lr_reg      <= lr_next;
        lp_reg      <= lp_next;
        before_reg  <= before_next;
        after_reg   <= after_next;
        steps_reg   <= steps_next;
        pa_reg      <= pa_next;
        na_reg      <= na_next;
        used_reg    <= used_next;
        req_reg     <= req_next;
        res_pay_reg <= res_pay_next;
        res_st_reg  <= res_st_next;
        opay_reg    <= opay_next;
        ost_reg     <= ost_next;
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_INIT:
            begin
                if (cnt_reg == 3'd5)
                begin
                    state_next = S_G0;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    if ((op == OP_ALLOC) && (request_bytes == 20'd0))
                    begin
                        state_next = S_DONE;
                    end
                    else if ((op == OP_FREE) && (block_address == 16'd0))
                    begin
                        state_next = S_DONE;
                    end
                    else if (op == OP_ALLOC)
                    begin
                        state_next = S_A0;
                    end
                    else
                    begin
                        state_next = S_FR0;
                    end
                end
            end
            S_A0:    state_next = S_F0;
            S_F0:
            begin
                if ((p_reg == 32'd0) || (steps_reg >= LIMIT_W))
                begin
                    state_next = S_G0;
                end
                else
                begin
                    state_next = S_F1;
                end
            end
            S_F1:    state_next = (d_sz >= asize_reg) ? S_C0 : S_F2;
            S_F2:    state_next = S_F0;
            S_G0:    state_next = S_G1;
            S_G1:
            begin
                if (grow_fail)
                begin
                    state_next = (merge_ret_reg == S_C0) ? S_DONE : S_IDLE;
                end
                else
                begin
                    state_next = S_G2;
                end
            end
            S_G2:    state_next = S_G3;
            S_G3:    state_next = S_M0;
            S_M0:    state_next = S_M1;
            S_M1:    state_next = S_M2;
            S_M2:    state_next = S_M3;
            S_M3:    state_next = S_M4;
            S_M4:    state_next = S_M5;
            S_M5:    state_next = S_M6;
            S_M6:    state_next = (pa_reg && na_reg) ? S_P0 : S_R0;
            S_MPUSH: state_next = S_P0;
            S_MREM2: state_next = S_R0;
            S_MW0:   state_next = S_MW1;
            S_MW1:   state_next = S_MRET;
            S_MRET:  state_next = merge_ret_reg;
            S_R0:    state_next = S_R1;
            S_R1:    state_next = S_R2;
            S_R2:    state_next = S_R3;
            S_R3:    state_next = link_ret_reg;
            S_P0:    state_next = S_P1;
            S_P1:    state_next = S_P2;
            S_P2:    state_next = link_ret_reg;
            S_C0:    state_next = S_C1;
            S_C1:
            begin
                if ({rdata[31:3], 3'b000} >= (asize_reg + MIN_BLOCK))
                begin
                    state_next = rdata[0] ? S_C2 : S_R0;
                end
                else
                begin
                    state_next = S_C6;
                end
            end
            S_C2:    state_next = S_C3;
            S_C3:    state_next = S_C4;
            S_C4:    state_next = S_C5;
            S_C5:    state_next = S_P0;
            S_C6:    state_next = S_C7;
            S_C7:    state_next = used_reg ? S_CFIN : S_R0;
            S_CFIN:  state_next = S_DONE;
            S_FR0:   state_next = S_FR1;
            S_FR1:   state_next = S_FR2;
            S_FR2:   state_next = S_M0;
            S_FRFIN: state_next = S_DONE;
            S_DONE:  state_next = out_free ? S_IDLE : S_DONE;
            default: state_next = S_IDLE;
        endcase
    end

    // Datapath, memory requests and results.
    always_comb
    begin
        link_ret_next  = link_ret_reg;
        merge_ret_next = merge_ret_reg;
        cnt_next       = cnt_reg;
        bp_next        = bp_reg;
        p_next         = p_reg;
        n_next         = n_reg;
        size_next      = size_reg;
        psz_next       = psz_reg;
        nsz_next       = nsz_reg;
        asize_next     = asize_reg;
        total_next     = total_reg;
        gbytes_next    = gbytes_reg;
        lr_next        = lr_reg;
        lp_next        = lp_reg;
        before_next    = before_reg;
        after_next     = after_reg;
        head_next      = head_reg;
        brk_next       = brk_reg;
        steps_next     = steps_reg;
        pa_next        = pa_reg;
        na_next        = na_reg;
        used_next      = used_reg;
        req_next       = req_reg;
        res_pay_next   = res_pay_reg;
        res_st_next    = res_st_reg;
        opay_next      = opay_reg;
        ost_next       = ost_reg;
        mem_req        = '0;

        // Output register drains independently of the sequencer.
        ovalid_next = (ovalid_reg && !out_ready) ? 1'b1 : 1'b0;

        unique case (state_reg)
            // Pad, prologue and epilogue words, then the first chunk.
            S_INIT:
            begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = {27'd0, cnt_reg, 2'b00};
                unique case (cnt_reg)
                    3'd3, 3'd4: mem_req.wr_data = TAG_PROLOGUE;
                    3'd5:       mem_req.wr_data = TAG_EPILOGUE;
                    default:    mem_req.wr_data = 32'd0;
                endcase
                cnt_next = cnt_reg + 3'd1;
                if (cnt_reg == 3'd5)
                begin
                    gbytes_next    = CHUNK_W;
                    merge_ret_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    req_next     = request_bytes;
                    bp_next      = {16'd0, block_address};
                    res_pay_next = 16'd0;
                    res_st_next  = ST_IGNORED;
                end
            end
            // Allocate: round the size and start the walk at the list head.
            S_A0:
            begin
                asize_next = (req_round <= 21'd24) ? MIN_BLOCK : {11'd0, req_round};
                p_next     = {16'd0, head_reg};
                steps_next = '0;
            end
            S_F0:
            begin
                if ((p_reg == 32'd0) || (steps_reg >= LIMIT_W))
                begin
                    gbytes_next    = (asize_reg > CHUNK_W) ? asize_reg : CHUNK_W;
                    merge_ret_next = S_C0;
                end
                else
                begin
                    mem_req.rd_addr = p_reg - 32'd4;
                end
            end
            S_F1:
            begin
                if (d_sz >= asize_reg)
                begin
                    bp_next = p_reg;
                end
                else
                begin
                    mem_req.rd_addr = p_reg + 32'd8;
                end
            end
            S_F2:
            begin
                p_next     = rdata;
                steps_next = steps_reg + SW'(1);
            end
            // Heap growth at the break.
            S_G0:
            begin
                size_next = ((gbytes_reg & ~32'd3) + 32'd7) & ~32'd7;
            end
            S_G1:
            begin
                if (grow_fail)
                begin
                    res_pay_next = 16'd0;
                    res_st_next  = ST_NOMEM;
                end
                else
                begin
                    bp_next         = brk_w;
                    mem_req.wr_en   = 1'b1;
                    mem_req.wr_addr = brk_w - 32'd4;
                    mem_req.wr_data = size_reg;
                end
            end
            S_G2:
            begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = bp_reg + size_reg - 32'd8;
                mem_req.wr_data = size_reg;
            end
            S_G3:
            begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = bp_reg + size_reg - 32'd4;
                mem_req.wr_data = TAG_EPILOGUE;
                brk_next        = 17'(bp_reg + size_reg);
            end
            // Coalescing: gather neighbor tags.
            S_M0:
            begin
                mem_req.rd_addr = bp_reg - 32'd8;
            end
            S_M1:
            begin
                p_next          = bp_reg - d_sz;
                mem_req.rd_addr = bp_reg - 32'd4;
            end
            S_M2:
            begin
                size_next       = d_sz;
                n_next          = bp_reg + d_sz;
                mem_req.rd_addr = p_reg - 32'd4;
            end
            S_M3:
            begin
                psz_next        = d_sz;
                mem_req.rd_addr = p_reg + d_sz - 32'd8;
            end
            S_M4:
            begin
                pa_next         = rdata[0];
                mem_req.rd_addr = n_reg - 32'd4;
            end
            S_M5:
            begin
                na_next         = rdata[0];
                nsz_next        = d_sz;
                mem_req.rd_addr = n_reg + d_sz - 32'd8;
            end
            S_M6:
            begin
                priority if (pa_reg && na_reg)
                begin
                    lp_next       = bp_reg;
                    link_ret_next = S_MRET;
                end
                else if (pa_reg)
                begin
                    size_next     = size_reg + nsz_reg;
                    lr_next       = n_reg;
                    lp_next       = bp_reg;
                    link_ret_next = S_MPUSH;
                end
                else if (na_reg)
                begin
                    size_next     = size_reg + psz_reg;
                    bp_next       = p_reg;
                    lr_next       = p_reg;
                    lp_next       = p_reg;
                    link_ret_next = S_MPUSH;
                end
                else
                begin
                    size_next     = size_reg + psz_reg + d_sz;
                    bp_next       = p_reg;
                    lr_next       = p_reg;
                    lp_next       = p_reg;
                    link_ret_next = S_MREM2;
                end
            end
            S_MREM2:
            begin
                lr_next       = n_reg;
                link_ret_next = S_MPUSH;
            end
            S_MPUSH:
            begin
                link_ret_next = S_MW0;
            end
            // New tags of the merged block.
            S_MW0:
            begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = bp_reg - 32'd4;
                mem_req.wr_data = size_reg;
            end
            S_MW1:
            begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = bp_reg + (inr(bp_reg - 32'd4) ?
                                  {size_reg[31:3], 3'b000} : 32'd0) - 32'd8;
                mem_req.wr_data = size_reg;
            end
            S_MRET:
            begin
            end
            // Unlink a block from the free list.
            S_R0:
            begin
                mem_req.rd_addr = lr_reg;
            end
            S_R1:
            begin
                before_next     = rdata;
                mem_req.rd_addr = lr_reg + 32'd8;
            end
            S_R2:
            begin
                after_next = rdata;
                if (before_reg == 32'd0)
                begin
                    head_next = rdata[15:0];
                end
                else
                begin
                    mem_req.wr_en   = 1'b1;
                    mem_req.wr_addr = before_reg + 32'd8;
                    mem_req.wr_data = rdata;
                end
            end
            S_R3:
            begin
                if (after_reg != 32'd0)
                begin
                    mem_req.wr_en   = 1'b1;
                    mem_req.wr_addr = after_reg;
                    mem_req.wr_data = before_reg;
                end
            end
            // Push a block at the list head.
            S_P0:
            begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = lp_reg + 32'd8;
                mem_req.wr_data = {16'd0, head_reg};
            end
            S_P1:
            begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = lp_reg;
                mem_req.wr_data = 32'd0;
            end
            S_P2:
            begin
                if (head_reg != 16'd0)
                begin
                    mem_req.wr_en   = 1'b1;
                    mem_req.wr_addr = {16'd0, head_reg};
                    mem_req.wr_data = lp_reg;
                end
                head_next = lp_reg[15:0];
            end
            // Carve the chosen block.
            S_C0:
            begin
                mem_req.rd_addr = bp_reg - 32'd4;
            end
            S_C1:
            begin
                total_next = d_sz;
                used_next  = rdata[0];
                if ((d_sz >= (asize_reg + MIN_BLOCK)) && !rdata[0])
                begin
                    lr_next       = bp_reg;
                    link_ret_next = S_C2;
                end
            end
            S_C2:
            begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = bp_reg - 32'd4;
                mem_req.wr_data = asize_reg | 32'd1;
            end
            S_C3:
            begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = bp_reg + (inr(bp_reg - 32'd4) ? asize_reg : 32'd0) - 32'd8;
                mem_req.wr_data = asize_reg | 32'd1;
                n_next          = bp_reg + (inr(bp_reg - 32'd4) ? asize_reg : 32'd0);
                size_next       = total_reg - asize_reg;
            end
            S_C4:
            begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = n_reg - 32'd4;
                mem_req.wr_data = size_reg;
            end
            S_C5:
            begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = n_reg + (inr(n_reg - 32'd4) ? size_reg : 32'd0) - 32'd8;
                mem_req.wr_data = size_reg;
                lp_next         = n_reg;
                link_ret_next   = S_CFIN;
            end
            S_C6:
            begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = bp_reg - 32'd4;
                mem_req.wr_data = total_reg | 32'd1;
            end
            S_C7:
            begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = bp_reg + (inr(bp_reg - 32'd4) ? total_reg : 32'd0) - 32'd8;
                mem_req.wr_data = total_reg | 32'd1;
                lr_next         = bp_reg;
                link_ret_next   = S_CFIN;
            end
            S_CFIN:
            begin
                res_pay_next = bp_reg[15:0];
                res_st_next  = ST_OK;
            end
            // Free: clear the allocated bit, then coalesce.
            S_FR0:
            begin
                mem_req.rd_addr = bp_reg - 32'd4;
            end
            S_FR1:
            begin
                size_next       = d_sz;
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = bp_reg - 32'd4;
                mem_req.wr_data = d_sz;
            end
            S_FR2:
            begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = bp_reg + (inr(bp_reg - 32'd4) ? size_reg : 32'd0) - 32'd8;
                mem_req.wr_data = size_reg;
                merge_ret_next  = S_FRFIN;
            end
            S_FRFIN:
            begin
                res_pay_next = 16'd0;
                res_st_next  = ST_OK;
            end
            // Hand the result to the output register.
            S_DONE:
            begin
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    opay_next   = res_pay_reg;
                    ost_next    = res_st_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

### rtl/explicit_free_list_allocator.sv
// Explicit free list heap allocator, first fit, with boundary tags.
// A free merges the block with any free neighbors. An allocate walks the free list
// and grows the heap when no listed block fits. One item at a time, ready only when
// idle. The rate is set by the heap memory, one heap word per cycle while the result
// output is not held. After reset the block lays out the heap before it is ready.
module explicit_free_list_allocator
    import efla_pkg::*;
#(
    parameter int HEAP_BYTES  = HEAP_BYTES_DEF,
    parameter int CHUNK_BYTES = CHUNK_BYTES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // request_bytes[19:0], block_address[15:0]
    input  logic        s_tuser,   // op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // payload_address[15:0], status[1:0]
);

    mem_req_t    mem_req;
    logic [31:0] rdata;
    logic [15:0] payload_address;
    logic [1:0]  status;

    efla_ctrl #(
        .HEAP_BYTES  (HEAP_BYTES),
        .CHUNK_BYTES (CHUNK_BYTES)
    ) u_ctrl (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (s_tvalid),
        .in_ready        (s_tready),
        .op              (s_tuser),
        .request_bytes   (s_tdata[19:0]),
        .block_address   (s_tdata[35:20]),
        .out_valid       (m_tvalid),
        .out_ready       (m_tready),
        .payload_address (payload_address),
        .status          (status),
        .mem_req         (mem_req),
        .rdata           (rdata)
    );

    efla_mem #(
        .HEAP_BYTES (HEAP_BYTES)
    ) u_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mem_req),
        .rdata (rdata)
    );

    assign m_tdata = {6'd0, status, payload_address};

endmodule

### dv/efla_checker.sv
`timescale 1ns / 1ps
// Result checker for the explicit free list allocator: watches both streams.
// Predicts each result from its own heap image and compares it; uses efla_pkg.
module efla_checker
    import efla_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [39:0] s_tdata,   // request_bytes[19:0], block_address[15:0]
    input  logic        s_tuser,   // op
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,   // payload_address[15:0], status[1:0]
    output int          errors,
    output int          outstanding
);

    localparam logic [31:0] CAP_BYTES  = 32'd65536;
    localparam int          WORD_COUNT = 16384;
    localparam logic [31:0] WALK_LIMIT = CAP_BYTES / MIN_BLOCK + 32'd1;

    typedef struct packed {
        logic [15:0] payload;
        logic [1:0]  status;
    } alloc_result_t;

    logic [31:0]   heap_img [WORD_COUNT];
    logic [31:0]   brk;
    logic [31:0]   flhead;
    alloc_result_t pending_results [$];

    // Word access; anything beyond the capacity reads 0 and drops writes.
    function automatic logic [31:0] word_rd(logic [31:0] a);
        return (a >> 2) < WORD_COUNT ? heap_img[a >> 2] : 32'd0;
    endfunction

    function automatic void word_wr(logic [31:0] a, logic [31:0] v);
        if ((a >> 2) < WORD_COUNT)
        begin
            heap_img[a >> 2] = v;
        end
    endfunction

    function automatic logic [31:0] tag_sz(logic [31:0] a);
        return word_rd(a) & ~32'd7;
    endfunction

    function automatic logic tag_used(logic [31:0] a);
        return (word_rd(a) & 32'd1) != 32'd0;
    endfunction

    function automatic logic [31:0] next_bp(logic [31:0] bp);
        return bp + tag_sz(bp - 32'd4);
    endfunction

    function automatic logic [31:0] prev_bp(logic [31:0] bp);
        return bp - tag_sz(bp - 32'd8);
    endfunction

    function automatic logic [31:0] footer_of(logic [31:0] bp);
        return bp + tag_sz(bp - 32'd4) - 32'd8;
    endfunction

    // LIFO insert at the head of the free list.
    function automatic void flist_push(logic [31:0] bp);
        word_wr(bp + 32'd8, flhead);
        word_wr(bp, 32'd0);
        if (flhead != 0)
        begin
            word_wr(flhead, bp);
        end
        flhead = bp & 32'hFFFF;
    endfunction

    function automatic void flist_unlink(logic [31:0] bp);
        logic [31:0] pred;
        logic [31:0] succ;
        pred = word_rd(bp);
        succ = word_rd(bp + 32'd8);
        if (pred == 0)
        begin
            flhead = succ & 32'hFFFF;
        end
        else
        begin
            word_wr(pred + 32'd8, succ);
        end
        if (succ != 0)
        begin
            word_wr(succ, pred);
        end
    endfunction

    // Merge a newly free block with free neighbors and list the result.
    function automatic logic [31:0] coalesce(logic [31:0] bp);
        logic        prev_used;
        logic        next_used;
        logic [31:0] size;
        logic [31:0] p;
        logic [31:0] n;
        prev_used = tag_used(footer_of(prev_bp(bp)));
        next_used = tag_used(next_bp(bp) - 32'd4);
        size = tag_sz(bp - 32'd4);
        if (prev_used && next_used)
        begin
            flist_push(bp);
            return bp;
        end
        else if (prev_used)
        begin
            n = next_bp(bp);
            size += tag_sz(n - 32'd4);
            flist_unlink(n);
            flist_push(bp);
        end
        else if (next_used)
        begin
            p = prev_bp(bp);
            size += tag_sz(p - 32'd4);
            bp = p;
            flist_unlink(bp);
            flist_push(bp);
        end
        else
        begin
            p = prev_bp(bp);
            n = next_bp(bp);
            size += tag_sz(p - 32'd4) + tag_sz(footer_of(n));
            bp = p;
            flist_unlink(p);
            flist_unlink(n);
            flist_push(bp);
        end
        word_wr(bp - 32'd4, size);
        word_wr(footer_of(bp), size);
        return bp;
    endfunction

    // Move the break up; returns 0 when the capacity would be exceeded.
    function automatic logic [31:0] grow_heap(logic [31:0] bytes);
        logic [31:0] size;
        logic [31:0] bp;
        size = (((bytes / 4) * 4) + 32'd7) & ~32'd7;
        if (brk > CAP_BYTES || size > CAP_BYTES - brk)
        begin
            return 32'd0;
        end
        bp = brk;
        word_wr(bp - 32'd4, size);
        word_wr(bp + size - 32'd8, size);
        word_wr(bp + size - 32'd4, 32'd1);
        brk = bp + size;
        return coalesce(bp);
    endfunction

    function automatic logic [31:0] search_list(logic [31:0] asize);
        logic [31:0] p;
        logic [31:0] steps;
        p = flhead;
        steps = 0;
        while (p != 0 && steps < WALK_LIMIT)
        begin
            if (tag_sz(p - 32'd4) >= asize)
            begin
                return p;
            end
            p = word_rd(p + 32'd8);
            steps++;
        end
        return 32'd0;
    endfunction

    // Mark the block used, splitting off the tail when it is big enough.
    function automatic void place(logic [31:0] bp, logic [31:0] asize);
        logic [31:0] total;
        logic        was_used;
        logic [31:0] n;
        total = tag_sz(bp - 32'd4);
        was_used = tag_used(bp - 32'd4);
        if (total >= asize && total - asize >= MIN_BLOCK)
        begin
            if (!was_used)
            begin
                flist_unlink(bp);
            end
            word_wr(bp - 32'd4, asize | 32'd1);
            word_wr(footer_of(bp), asize | 32'd1);
            n = next_bp(bp);
            word_wr(n - 32'd4, total - asize);
            word_wr(footer_of(n), total - asize);
            flist_push(n);
        end
        else
        begin
            word_wr(bp - 32'd4, total | 32'd1);
            word_wr(footer_of(bp), total | 32'd1);
            if (!was_used)
            begin
                flist_unlink(bp);
            end
        end
    endfunction

    function automatic alloc_result_t predict_result(logic op, logic [19:0] req,
                                                     logic [15:0] addr);
        alloc_result_t r;
        logic [31:0]   asize;
        logic [31:0]   bp;
        logic [31:0]   size;
        r = '{payload: 16'd0, status: ST_OK};
        if (op == OP_ALLOC)
        begin
            if (req == 0)
            begin
                r.status = ST_IGNORED;
            end
            else
            begin
                asize = (32'(req) + 32'd15) & ~32'd7;
                if (asize <= MIN_BLOCK)
                begin
                    asize = MIN_BLOCK;
                end
                bp = search_list(asize);
                if (bp == 0)
                begin
                    bp = grow_heap(asize > 32'd2048 ? asize : 32'd2048);
                end
                if (bp == 0)
                begin
                    r.status = ST_NOMEM;
                end
                else
                begin
                    place(bp, asize);
                    r.payload = bp[15:0];
                end
            end
        end
        else if (addr == 0)
        begin
            r.status = ST_IGNORED;
        end
        else
        begin
            size = tag_sz(32'(addr) - 32'd4);
            word_wr(32'(addr) - 32'd4, size);
            word_wr(footer_of(32'(addr)), size);
            void'(coalesce(32'(addr)));
        end
        return r;
    endfunction

    // Heap image after reset: pad, prologue, epilogue and the first chunk.
    initial
    begin
        errors = 0;
        outstanding = 0;
        for (int i = 0; i < WORD_COUNT; i++)
        begin
            heap_img[i] = 32'd0;
        end
        flhead = 0;
        word_wr(32'd12, TAG_PROLOGUE);
        word_wr(32'd16, TAG_PROLOGUE);
        word_wr(32'd20, TAG_EPILOGUE);
        brk = 32'd24;
        void'(grow_heap(32'd2048));
    end

    // Compare each returned item, then predict for each accepted one.
    always @(posedge clk)
    begin
        alloc_result_t want;
        alloc_result_t got;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got = '{payload: m_tdata[15:0], status: m_tdata[17:16]};
                if (pending_results.size() == 0)
                begin
                    errors++;
                    $display("%t: unexpected result payload=%0d status=%0d",
                             $realtime, got.payload, got.status);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (got.payload !== want.payload)
                    begin
                        errors++;
                        $display("%t: payload mismatch: expected %0d, actual %0d",
                                 $realtime, want.payload, got.payload);
                    end
                    if (got.status !== want.status)
                    begin
                        errors++;
                        $display("%t: status mismatch: expected %0d, actual %0d",
                                 $realtime, want.status, got.status);
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                pending_results.push_back(predict_result(s_tuser, s_tdata[19:0],
                                                         s_tdata[35:20]));
            end
            outstanding = pending_results.size();
        end
    end

    final
    begin
    end

endmodule

### dv/tb_explicit_free_list_allocator.sv
`timescale 1ns / 1ps
// Testbench top for the explicit free list allocator: stimulus and verdict.
// Depends on efla_pkg, the block itself and efla_checker.
module tb_explicit_free_list_allocator
    import efla_pkg::*;
();

    localparam int CYCLE_LIMIT  = 3000000;
    localparam int RANDOM_ITEMS = 430;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;   // request_bytes[19:0], block_address[15:0]
    logic        s_tuser = 1'b0; // op
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;        // payload_address[15:0], status[1:0]

    int          errors;
    int          outstanding;
    int          tx_idle_pct = 13;
    int          rx_idle_pct = 78;
    bit          long_hold_go = 1'b0;
    int          cycle_count = 0;
    int          n_alloc = 0;
    int          n_free = 0;
    int          n_nomem = 0;
    logic        sent_ops [$];
    logic [15:0] live_blocks [$];

    explicit_free_list_allocator dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    efla_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .errors(errors), .outstanding(outstanding)
    );

    always #10 clk = ~clk;

    // Run limit.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // Receiver: random stalls, plus one long hold-off on request.
    always @(posedge clk)
    begin
        static int  hold_left = 0;
        static bit  hold_done = 1'b0;
        if (rst_n)
        begin
            if (long_hold_go && !hold_done)
            begin
                hold_left = 400;
                hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // Track live payloads from returned allocations.
    always @(posedge clk)
    begin
        logic op;
        if (rst_n && m_tvalid && m_tready && sent_ops.size() > 0)
        begin
            op = sent_ops.pop_front();
            if (m_tdata[17:16] == ST_NOMEM)
            begin
                n_nomem++;
            end
            if (op == OP_ALLOC && m_tdata[17:16] == ST_OK)
            begin
                live_blocks.push_back(m_tdata[15:0]);
            end
        end
    end

    task automatic send_item(input logic op, input logic [19:0] req, input logic [15:0] addr);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {4'b0000, addr, req};
        s_tuser <= op;
        do
            @(posedge clk);
        while (!s_tready);
        sent_ops.push_back(op);
        if (op == OP_ALLOC)
        begin
            n_alloc++;
        end
        else
        begin
            n_free++;
        end
    endtask

    // Stop offering and wait for every result to return.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        wait (outstanding == 0 && sent_ops.size() == 0);
        repeat (80) @(posedge clk);
    endtask

    task automatic free_live(input int idx);
        logic [15:0] a;
        a = live_blocks[idx];
        live_blocks.delete(idx);
        send_item(OP_FREE, 20'($urandom), a);
    endtask

    // Mostly allocate/free of live blocks with mixed sizes; a few ignored items.
    task automatic random_item();
        int          r;
        int          k;
        logic [19:0] req;
        r = $urandom_range(99);
        k = $urandom_range(99);
        if (k < 60)
        begin
            req = 20'($urandom_range(256, 1));
        end
        else if (k < 85)
        begin
            req = 20'($urandom_range(2048, 257));
        end
        else if (k < 95)
        begin
            req = 20'($urandom_range(16000, 2049));
        end
        else
        begin
            req = 20'($urandom);
        end
        if (r < 2)
        begin
            send_item(OP_ALLOC, 20'd0, 16'($urandom));
        end
        else if (r < 4)
        begin
            send_item(OP_FREE, 20'($urandom), 16'd0);
        end
        else if (r < 45 && live_blocks.size() > 0)
        begin
            free_live($urandom_range(live_blocks.size() - 1));
        end
        else
        begin
            send_item(OP_ALLOC, req, 16'($urandom));
        end
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: ignored items, minimum size, rounding, growth and oversize.
        send_item(OP_ALLOC, 20'd0, 16'hFFFF);
        send_item(OP_FREE, 20'hFFFFF, 16'd0);
        send_item(OP_ALLOC, 20'd1, 16'd0);
        send_item(OP_ALLOC, 20'd16, 16'd0);
        send_item(OP_ALLOC, 20'd17, 16'd0);
        send_item(OP_ALLOC, 20'd100, 16'd0);
        send_item(OP_ALLOC, 20'd2040, 16'd0);
        send_item(OP_ALLOC, 20'hFFFFF, 16'd0);
        send_item(OP_ALLOC, 20'd60000, 16'd0);
        send_item(OP_ALLOC, 20'd30000, 16'd0);
        send_item(OP_ALLOC, 20'd20000, 16'd0);
        send_item(OP_ALLOC, 20'd8, 16'd0);
        drain();
        // Free neighbors so merges happen on each side and on both.
        free_live(2);
        free_live(0);
        free_live(0);
        free_live(live_blocks.size() - 1);
        free_live(live_blocks.size() - 1);
        send_item(OP_ALLOC, 20'd40, 16'd0);
        drain();

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == RANDOM_ITEMS / 3)
            begin
                tx_idle_pct = 78;
                rx_idle_pct = 13;
            end
            if (i == 2 * RANDOM_ITEMS / 3)
            begin
                // Sender pause until everything is back, then full rate.
                drain();
                tx_idle_pct = 0;
                rx_idle_pct = 0;
                long_hold_go = 1'b1;
            end
            random_item();
        end
        drain();

        $display("Sent %0d allocations and %0d frees; %0d ran out of memory.",
                 n_alloc, n_free, n_nomem);
        $display("Covered ignored items, splits, merges, heap growth and capacity limits.");
        if (errors == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
